// File: hw/rtl/mwo_pkg.sv
// Shared types, constants and functions of the multi-waveform oscillator.
`default_nettype none

package mwo_pkg;

  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned WAVE_W   = 3;

  // Default width of the sine table index taken from the top of the phase.
  localparam int unsigned SINE_INDEX_BITS_DEF = 12;

  // Digit width of the serial phase adder.
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned DIGITS     = PHASE_W / DIGIT_W;
  localparam int unsigned DIGIT_CNT_W = $clog2(DIGITS);

  // Serial divider: quotient always fits in the duty width.
  localparam int unsigned DIV_Q_W   = DUTY_W;
  localparam int unsigned DIV_D_W   = DUTY_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_Q_W);

  typedef logic [PHASE_W-1:0]         phase_t;
  typedef logic [DUTY_W-1:0]          duty_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [WAVE_W-1:0]          wave_t;

  localparam wave_t WAVE_SINE      = 3'd0;
  localparam wave_t WAVE_SQUARE    = 3'd1;
  localparam wave_t WAVE_SAWTOOTH  = 3'd2;
  localparam wave_t WAVE_TRIANGLE  = 3'd3;
  localparam wave_t WAVE_PULSE     = 3'd4;
  localparam wave_t WAVE_TRI_PULSE = 3'd5;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_EVAL,
    ST_DIV,
    ST_FINISH
  } state_t;

  // Status of a serial unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // Quarter-wave sine in Q15 by an 11th-order Taylor polynomial in Q2.30.
  // Used only while the design elaborates, to build the table contents.
  function automatic logic [SAMPLE_W-1:0] quarter_sine(input int unsigned r,
                                                      input int unsigned qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (PI_HALF_Q30 * 64'(r)) >> qbits;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    s  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return SAMPLE_W'(s);
  endfunction

  // Clamp an 18-bit signed value to the sample range.
  function automatic sample_t sat_sample(input logic signed [SAMPLE_W+1:0] v);
    sample_t res;
    if (v > 18'sd32767) begin
      res = SAMPLE_MAX;
    end else if (v < -18'sd32768) begin
      res = SAMPLE_MIN;
    end else begin
      res = sample_t'(v[SAMPLE_W-1:0]);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mwo_if.sv
// Valid/ready channel interfaces for sample ticks and output samples.
`default_nettype none

interface mwo_tick_if;
  logic            valid;
  logic            ready;
  mwo_pkg::phase_t phase_step;
  mwo_pkg::duty_t  duty;

  modport source (output valid, output phase_step, output duty, input ready);
  modport sink   (input valid, input phase_step, input duty, output ready);
endinterface

interface mwo_sample_if;
  logic             valid;
  logic             ready;
  mwo_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mwo_phase_acc.sv
// Phase accumulator that adds the phase step one digit per cycle.
`default_nettype none

module mwo_phase_acc (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire mwo_pkg::phase_t       step,
  output mwo_pkg::phase_t            phase,
  output mwo_pkg::unit_status_t      status
);

  mwo_pkg::phase_t                      step_sr;
  logic                                 carry;
  logic                                 running;
  logic [mwo_pkg::DIGIT_CNT_W-1:0]      cnt;
  logic [mwo_pkg::DIGIT_W:0]            digit_sum;

  assign digit_sum = {1'b0, phase[mwo_pkg::DIGIT_W-1:0]}
                   + {1'b0, step_sr[mwo_pkg::DIGIT_W-1:0]}
                   + {{mwo_pkg::DIGIT_W{1'b0}}, carry};

  assign status.busy = running;
  assign status.done = running && (cnt == mwo_pkg::DIGIT_CNT_W'(mwo_pkg::DIGITS - 1));

  // The phase rotates right by one digit per cycle, so after a full turn
  // every digit is back in place and holds the sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= '0;
      running <= 1'b0;
      cnt     <= '0;
      carry   <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= '0;
      carry   <= 1'b0;
    end else if (running) begin
      phase   <= {digit_sum[mwo_pkg::DIGIT_W-1:0], phase[mwo_pkg::PHASE_W-1:mwo_pkg::DIGIT_W]};
      carry   <= digit_sum[mwo_pkg::DIGIT_W];
      cnt     <= cnt + 1'b1;
      if (status.done) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step_sr <= step;
    end else if (running) begin
      step_sr <= step_sr >> mwo_pkg::DIGIT_W;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mwo_sine_rom.sv
// Quarter-wave sine table with a registered read port.
`default_nettype none

module mwo_sine_rom #(
  parameter int unsigned SINE_INDEX_BITS = mwo_pkg::SINE_INDEX_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic [SINE_INDEX_BITS-2:0]  addr,
  output logic [mwo_pkg::SAMPLE_W-1:0]     data
);

  localparam int unsigned QBITS = SINE_INDEX_BITS - 2;
  localparam int unsigned QLEN  = 1 << QBITS;

  // One entry more than a quarter so that the peak needs no special case.
  logic [mwo_pkg::SAMPLE_W-1:0] rom_const [QLEN+1];

  for (genvar k = 0; k <= QLEN; k++) begin : g_entry
    localparam logic [mwo_pkg::SAMPLE_W-1:0] ENTRY = mwo_pkg::quarter_sine(k, QBITS);
    assign rom_const[k] = ENTRY;
  end

  always_ff @(posedge clk) begin
    data <= rom_const[addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/mwo_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module mwo_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire mwo_pkg::phase_t               num,
  input  wire logic [mwo_pkg::DIV_D_W-1:0]   den,
  output logic [mwo_pkg::DIV_Q_W-1:0]        quot,
  output mwo_pkg::unit_status_t              status
);

  logic [mwo_pkg::DIV_D_W-1:0]   den_q;
  logic [mwo_pkg::DIV_D_W-1:0]   rem;
  logic [mwo_pkg::DIV_Q_W-1:0]   num_sr;
  logic [mwo_pkg::DIV_CNT_W-1:0] cnt;
  logic                          running;
  logic [mwo_pkg::DIV_D_W:0]     trial;
  logic                          fits;

  // The caller guarantees num < den * 2^16, so the upper half of the
  // numerator is already a valid partial remainder.
  assign trial = {rem, num_sr[mwo_pkg::DIV_Q_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  assign status.busy = running;
  assign status.done = running && (cnt == mwo_pkg::DIV_CNT_W'(mwo_pkg::DIV_Q_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= '0;
    end else if (running) begin
      cnt <= cnt + 1'b1;
      if (status.done) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_q  <= den;
      rem    <= {1'b0, num[mwo_pkg::PHASE_W-1:mwo_pkg::DIV_Q_W]};
      num_sr <= num[mwo_pkg::DIV_Q_W-1:0];
    end else if (running) begin
      rem    <= fits ? mwo_pkg::DIV_D_W'(trial - {1'b0, den_q})
                     : trial[mwo_pkg::DIV_D_W-1:0];
      num_sr <= num_sr << 1;
      quot   <= {quot[mwo_pkg::DIV_Q_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/multi_waveform_oscillator_top.sv
// Top level of the multi-waveform phase-accumulator oscillator.
//
//   channel   dir  payload                     beat taken when
//   tick      in   phase_step[31:0], duty[15:0] tick.valid && tick.ready
//   result    out  sample[15:0] signed Q1.15    result.valid && result.ready
//   cfg_wr_*  in   waveform[2:0]                cfg_wr_en
//
// A tick beat passes through the ADD, EVAL and FINISH states, with a DIV state
// before FINISH for triangle pulse: the phase add runs one 4-bit digit per cycle
// and the triangle pulse division one quotient bit per cycle.
// Reset clears the phase and selects the sine waveform.
// The output register holds a finished sample while the next tick is taken;
// a stalled result only blocks the sequencer when the next sample is ready.
`default_nettype none

module multi_waveform_oscillator_top #(
  parameter int unsigned SINE_INDEX_BITS = mwo_pkg::SINE_INDEX_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  mwo_tick_if.sink                  tick,
  mwo_sample_if.source              result,
  input  wire logic                 cfg_wr_en,
  input  wire mwo_pkg::wave_t       cfg_wr_data
);

  localparam int unsigned QBITS = SINE_INDEX_BITS - 2;
  localparam int unsigned QLEN  = 1 << QBITS;

  mwo_pkg::state_t        state;
  mwo_pkg::state_t        state_next;
  mwo_pkg::wave_t         waveform;
  mwo_pkg::duty_t         duty;
  mwo_pkg::phase_t        phase;
  mwo_pkg::unit_status_t  add_status;
  mwo_pkg::unit_status_t  div_status;
  logic                   add_start;
  logic                   div_start;
  logic                   out_load;
  logic                   out_valid;
  mwo_pkg::sample_t       sample;
  mwo_pkg::sample_t       sample_next;

  // Sine addressing by quarter-wave symmetry.
  logic [SINE_INDEX_BITS-1:0]   sine_idx;
  logic [QBITS-1:0]             sine_r;
  logic [QBITS:0]               rom_addr;
  logic [mwo_pkg::SAMPLE_W-1:0] rom_data;

  // Triangle pulse division operands.
  mwo_pkg::phase_t               duty_edge;
  logic                          tp_rise;
  mwo_pkg::phase_t               div_num;
  logic [mwo_pkg::DIV_D_W-1:0]   div_den;
  logic [mwo_pkg::DIV_Q_W-1:0]   div_quot;
  logic signed [mwo_pkg::SAMPLE_W+1:0] tri_v;

  assign sine_idx = phase[mwo_pkg::PHASE_W-1 -: SINE_INDEX_BITS];
  assign sine_r   = sine_idx[QBITS-1:0];
  assign rom_addr = sine_idx[QBITS] ? (QBITS+1)'(QLEN) - {1'b0, sine_r} : {1'b0, sine_r};

  assign duty_edge = {duty, {mwo_pkg::DUTY_W{1'b0}}};
  assign tp_rise   = phase < duty_edge;
  assign div_num   = tp_rise ? phase : phase - duty_edge;
  assign div_den   = tp_rise ? {1'b0, duty}
                             : (mwo_pkg::DIV_D_W)'(1 << mwo_pkg::DUTY_W) - {1'b0, duty};

  mwo_phase_acc u_phase_acc (
    .clk    (clk),
    .rst    (rst),
    .start  (add_start),
    .step   (tick.phase_step),
    .phase  (phase),
    .status (add_status)
  );

  mwo_sine_rom #(
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_sine_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  mwo_divider u_divider (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .quot   (div_quot),
    .status (div_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform <= mwo_pkg::WAVE_SINE;
    end else if (cfg_wr_en) begin
      waveform <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (add_start) begin
      duty <= tick.duty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mwo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    tick.ready = 1'b0;
    add_start  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      mwo_pkg::ST_IDLE: begin
        tick.ready = 1'b1;
        if (tick.valid) begin
          add_start  = 1'b1;
          state_next = mwo_pkg::ST_ADD;
        end
      end
      mwo_pkg::ST_ADD: begin
        if (add_status.done) begin
          state_next = mwo_pkg::ST_EVAL;
        end
      end
      mwo_pkg::ST_EVAL: begin
        // The sine table read is registered here; it is valid in FINISH.
        if (waveform == mwo_pkg::WAVE_TRI_PULSE) begin
          div_start  = 1'b1;
          state_next = mwo_pkg::ST_DIV;
        end else begin
          state_next = mwo_pkg::ST_FINISH;
        end
      end
      mwo_pkg::ST_DIV: begin
        if (div_status.done) begin
          state_next = mwo_pkg::ST_FINISH;
        end
      end
      mwo_pkg::ST_FINISH: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = mwo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mwo_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    tri_v = '0;
    if (phase[mwo_pkg::PHASE_W-1:mwo_pkg::PHASE_W-2] == 2'b00) begin
      tri_v = {1'b0, phase[mwo_pkg::PHASE_W-1:15]};
    end else if (phase[mwo_pkg::PHASE_W-1:mwo_pkg::PHASE_W-2] != 2'b11) begin
      tri_v = 18'sd65536 - $signed({1'b0, phase[mwo_pkg::PHASE_W-1:15]});
    end else begin
      tri_v = $signed({1'b0, phase[mwo_pkg::PHASE_W-1:15]}) - 18'sd131072;
    end
  end

  always_comb begin
    sample_next = '0;
    case (waveform)
      mwo_pkg::WAVE_SINE: begin
        // The second half of the period is the negated quarter table.
        sample_next = phase[mwo_pkg::PHASE_W-1] ? mwo_pkg::sample_t'(16'd0 - rom_data)
                                                : mwo_pkg::sample_t'(rom_data);
      end
      mwo_pkg::WAVE_SQUARE: begin
        sample_next = phase[mwo_pkg::PHASE_W-1] ? mwo_pkg::SAMPLE_MIN : mwo_pkg::SAMPLE_MAX;
      end
      mwo_pkg::WAVE_SAWTOOTH: begin
        sample_next = {~phase[mwo_pkg::PHASE_W-1], phase[mwo_pkg::PHASE_W-2:16]};
      end
      mwo_pkg::WAVE_TRIANGLE: begin
        sample_next = mwo_pkg::sat_sample(tri_v);
      end
      mwo_pkg::WAVE_PULSE: begin
        sample_next = tp_rise ? mwo_pkg::SAMPLE_MAX : mwo_pkg::SAMPLE_MIN;
      end
      mwo_pkg::WAVE_TRI_PULSE: begin
        if (tp_rise) begin
          // A zero quotient would give +1.0, which saturates.
          sample_next = (div_quot == '0) ? mwo_pkg::SAMPLE_MAX
                                          : mwo_pkg::sample_t'(16'd0 - div_quot
                                                               + 16'h8000);
        end else begin
          sample_next = {~div_quot[mwo_pkg::DIV_Q_W-1], div_quot[mwo_pkg::DIV_Q_W-2:0]};
        end
      end
      default: begin
        sample_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample <= sample_next;
    end
  end

  assign result.valid  = out_valid;
  assign result.sample = sample;

  // An accepted beat always starts the serial phase add.
  a_tick_starts_add: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> add_status.busy)
    else $error("phase add did not start after a tick beat");

  // The phase only moves while the serial adder runs.
  a_phase_held: assert property (@(posedge clk) disable iff (rst)
    !add_status.busy |=> $stable(phase))
    else $error("phase changed outside the serial add");

  // The divider finishes only while the sequencer waits for it.
  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> state == mwo_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

endmodule

`default_nettype wire
